FILE: hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Clocked assertion, checked during reset as well.
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

FILE: hw/rtl/s256h_pkg.sv
package s256h_pkg;

   typedef logic [31:0] word_type;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_LOAD  = 3'd1;
   localparam logic [2:0] S_ROUND = 3'd2;
   localparam logic [2:0] S_ADD   = 3'd3;
   localparam logic [2:0] S_EMIT  = 3'd4;

   localparam logic [1:0] PM_NORM = 2'd0;
   localparam logic [1:0] PM_PADA = 2'd1;
   localparam logic [1:0] PM_PADL = 2'd2;
   localparam logic [1:0] PM_PADZ = 2'd3;

   localparam logic [5:0] LEN_LIMIT = 6'd56;
   localparam logic [7:0] PAD_BYTE  = 8'h80;

   function automatic word_type iv_of(input logic [2:0] i);
      word_type r;
      unique case (i)
         3'd0: r = 32'h6a09e667;
         3'd1: r = 32'hbb67ae85;
         3'd2: r = 32'h3c6ef372;
         3'd3: r = 32'ha54ff53a;
         3'd4: r = 32'h510e527f;
         3'd5: r = 32'h9b05688c;
         3'd6: r = 32'h1f83d9ab;
         3'd7: r = 32'h5be0cd19;
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic word_type rc_of(input logic [5:0] t);
      word_type r;
      unique case (t)
         6'd0:  r = 32'h428a2f98;  6'd1:  r = 32'h71374491;
         6'd2:  r = 32'hb5c0fbcf;  6'd3:  r = 32'he9b5dba5;
         6'd4:  r = 32'h3956c25b;  6'd5:  r = 32'h59f111f1;
         6'd6:  r = 32'h923f82a4;  6'd7:  r = 32'hab1c5ed5;
         6'd8:  r = 32'hd807aa98;  6'd9:  r = 32'h12835b01;
         6'd10: r = 32'h243185be;  6'd11: r = 32'h550c7dc3;
         6'd12: r = 32'h72be5d74;  6'd13: r = 32'h80deb1fe;
         6'd14: r = 32'h9bdc06a7;  6'd15: r = 32'hc19bf174;
         6'd16: r = 32'he49b69c1;  6'd17: r = 32'hefbe4786;
         6'd18: r = 32'h0fc19dc6;  6'd19: r = 32'h240ca1cc;
         6'd20: r = 32'h2de92c6f;  6'd21: r = 32'h4a7484aa;
         6'd22: r = 32'h5cb0a9dc;  6'd23: r = 32'h76f988da;
         6'd24: r = 32'h983e5152;  6'd25: r = 32'ha831c66d;
         6'd26: r = 32'hb00327c8;  6'd27: r = 32'hbf597fc7;
         6'd28: r = 32'hc6e00bf3;  6'd29: r = 32'hd5a79147;
         6'd30: r = 32'h06ca6351;  6'd31: r = 32'h14292967;
         6'd32: r = 32'h27b70a85;  6'd33: r = 32'h2e1b2138;
         6'd34: r = 32'h4d2c6dfc;  6'd35: r = 32'h53380d13;
         6'd36: r = 32'h650a7354;  6'd37: r = 32'h766a0abb;
         6'd38: r = 32'h81c2c92e;  6'd39: r = 32'h92722c85;
         6'd40: r = 32'ha2bfe8a1;  6'd41: r = 32'ha81a664b;
         6'd42: r = 32'hc24b8b70;  6'd43: r = 32'hc76c51a3;
         6'd44: r = 32'hd192e819;  6'd45: r = 32'hd6990624;
         6'd46: r = 32'hf40e3585;  6'd47: r = 32'h106aa070;
         6'd48: r = 32'h19a4c116;  6'd49: r = 32'h1e376c08;
         6'd50: r = 32'h2748774c;  6'd51: r = 32'h34b0bcb5;
         6'd52: r = 32'h391c0cb3;  6'd53: r = 32'h4ed8aa4a;
         6'd54: r = 32'h5b9cca4f;  6'd55: r = 32'h682e6ff3;
         6'd56: r = 32'h748f82ee;  6'd57: r = 32'h78a5636f;
         6'd58: r = 32'h84c87814;  6'd59: r = 32'h8cc70208;
         6'd60: r = 32'h90befffa;  6'd61: r = 32'ha4506ceb;
         6'd62: r = 32'hbef9a3f7;  6'd63: r = 32'hc67178f2;
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic word_type ror(input word_type x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

endpackage

FILE: hw/rtl/sha256_stream_hasher.sv
// SHA-256 over a byte stream.
// Input channel (req_): one beat per item. req_mode 0 absorbs req_data_byte,
// req_mode 1 finalizes the message: pads it, compresses, and emits the digest.
// Result channel (rsp_): eight beats per finalize, h0 first, rsp_word_index
// giving the position and rsp_last_word marking the eighth word.
// An absorb beat that does not fill a block leaves req_ready high; the beat
// that fills a 64-byte block starts a compression (a load step, 64 rounds at
// one round per cycle on the shared round unit, a chaining add). A finalize
// compresses one padded block, or two when 56 or more bytes are buffered,
// followed by the digest beats. Block words sit in a 16 x 32 synchronous
// memory read one word ahead of the round that uses it.
// The block takes one item at a time: req_ready is low while a block is
// compressed and while digest beats are pending.
// A stalled receiver holds the current digest beat; nothing is lost.
// Reset loads the initial hash values and clears the byte and bit counts;
// after the last digest beat the block returns to that same state.
module sha256_stream_hasher_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_mode,
   input  logic [7:0]              req_data_byte,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output s256h_pkg::word_type     rsp_digest_word,
   output logic [2:0]              rsp_word_index,
   output logic                    rsp_last_word
);
   import s256h_pkg::*;

   logic [2:0]  state_ff, state_in;
   logic [1:0]  pmode_ff;
   logic [5:0]  fill_ff;
   logic [63:0] bits_ff;
   logic [23:0] acc_ff;
   logic [5:0]  t_ff;
   logic [2:0]  idx_ff;
   word_type    chain_ff [8];
   word_type    v_ff [8];
   word_type    w_ff [16];

   word_type    blk_mem [16];
   word_type    rd_ff;
   logic [3:0]  rd_addr;
   logic        wr_en;

   logic        take;
   logic [3:0]  k;
   logic [3:0]  nw;
   word_type    part_word;
   word_type    blk_word;
   word_type    wt, s0, s1, t1, t2;

   assign take      = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_EMIT);
   assign rsp_digest_word = chain_ff[idx_ff];
   assign rsp_word_index  = idx_ff;
   assign rsp_last_word   = (idx_ff == 3'd7);

   assign wr_en   = take && !req_mode && (fill_ff[1:0] == 2'd3);
   assign rd_addr = (state_ff == S_LOAD) ? 4'd0 : t_ff[3:0] + 4'd1;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         blk_mem[fill_ff[5:2]] <= {acc_ff, req_data_byte};
      end
      rd_ff <= blk_mem[rd_addr];
   end

   assign k  = t_ff[3:0];
   assign nw = fill_ff[5:2];

   always_comb begin
      unique case (fill_ff[1:0])
         2'd0: part_word = {PAD_BYTE, 24'h0};
         2'd1: part_word = {acc_ff[7:0], PAD_BYTE, 16'h0};
         2'd2: part_word = {acc_ff[15:0], PAD_BYTE, 8'h0};
         2'd3: part_word = {acc_ff[23:0], PAD_BYTE};
         default: part_word = '0;
      endcase
      if (pmode_ff == PM_NORM) begin
         blk_word = rd_ff;
      end else if (pmode_ff == PM_PADZ) begin
         blk_word = '0;
      end else if (k < nw) begin
         blk_word = rd_ff;
      end else if (k == nw) begin
         blk_word = part_word;
      end else begin
         blk_word = '0;
      end
      if (pmode_ff == PM_PADL || pmode_ff == PM_PADZ) begin
         if (k == 4'd14) begin
            blk_word = bits_ff[63:32];
         end else if (k == 4'd15) begin
            blk_word = bits_ff[31:0];
         end
      end
   end

   always_comb begin
      s0 = ror(w_ff[1], 7) ^ ror(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1 = ror(w_ff[14], 17) ^ ror(w_ff[14], 19) ^ (w_ff[14] >> 10);
      wt = (t_ff < 6'd16) ? blk_word : w_ff[0] + s0 + w_ff[9] + s1;
      t1 = v_ff[7] + (ror(v_ff[4], 6) ^ ror(v_ff[4], 11) ^ ror(v_ff[4], 25))
         + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6])) + rc_of(t_ff) + wt;
      t2 = (ror(v_ff[0], 2) ^ ror(v_ff[0], 13) ^ ror(v_ff[0], 22))
         + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (take && (req_mode || fill_ff == 6'd63)) begin
               state_in = S_LOAD;
            end
         end
         S_LOAD:  state_in = S_ROUND;
         S_ROUND: begin
            if (t_ff == 6'd63) begin
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            priority if (pmode_ff == PM_PADA) begin
               state_in = S_LOAD;
            end else if (pmode_ff == PM_NORM) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (rsp_ready && idx_ff == 3'd7) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pmode_ff <= PM_NORM;
         fill_ff  <= '0;
         bits_ff  <= '0;
         t_ff     <= '0;
         idx_ff   <= '0;
         for (int i = 0; i < 8; i++) begin
            chain_ff[i] <= iv_of(3'(i));
         end
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            S_IDLE: begin
               if (take && !req_mode) begin
                  acc_ff  <= {acc_ff[15:0], req_data_byte};
                  fill_ff <= fill_ff + 6'd1;
                  bits_ff <= bits_ff + 64'd8;
                  pmode_ff <= PM_NORM;
               end else if (take) begin
                  pmode_ff <= (fill_ff >= LEN_LIMIT) ? PM_PADA : PM_PADL;
               end
            end
            S_LOAD: begin
               t_ff <= '0;
               for (int i = 0; i < 8; i++) begin
                  v_ff[i] <= chain_ff[i];
               end
            end
            S_ROUND: begin
               t_ff <= t_ff + 6'd1;
               for (int i = 0; i < 15; i++) begin
                  w_ff[i] <= w_ff[i+1];
               end
               w_ff[15] <= wt;
               v_ff[7] <= v_ff[6];
               v_ff[6] <= v_ff[5];
               v_ff[5] <= v_ff[4];
               v_ff[4] <= v_ff[3] + t1;
               v_ff[3] <= v_ff[2];
               v_ff[2] <= v_ff[1];
               v_ff[1] <= v_ff[0];
               v_ff[0] <= t1 + t2;
            end
            S_ADD: begin
               idx_ff <= '0;
               for (int i = 0; i < 8; i++) begin
                  chain_ff[i] <= chain_ff[i] + v_ff[i];
               end
               if (pmode_ff == PM_PADA) begin
                  pmode_ff <= PM_PADZ;
               end
            end
            S_EMIT: begin
               if (rsp_ready) begin
                  idx_ff <= idx_ff + 3'd1;
                  if (idx_ff == 3'd7) begin
                     fill_ff <= '0;
                     bits_ff <= '0;
                     for (int i = 0; i < 8; i++) begin
                        chain_ff[i] <= iv_of(3'(i));
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

endmodule

FILE: hw/rtl/s256h_checker.sv
`include "assert_macros.svh"

module s256h_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input s256h_pkg::word_type rsp_digest_word,
   input logic [2:0]          rsp_word_index,
   input logic                rsp_last_word
);
   `ASSERT_CLK(a_hold_beat, clock, reset,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_digest_word)
         && $stable(rsp_word_index))
   `ASSERT_CLK(a_no_take_while_emit, clock, reset, rsp_valid |-> !req_ready)
   `ASSERT_CLK(a_last_ends, clock, reset,
      rsp_valid && rsp_ready && rsp_last_word |=> !rsp_valid && req_ready)
   `ASSERT_CLK(a_last_index, clock, reset,
      !rsp_valid || (rsp_last_word == (rsp_word_index == 3'd7)))
   `ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid && req_ready)
endmodule

bind sha256_stream_hasher_core s256h_checker u_s256h_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_digest_word (rsp_digest_word),
   .rsp_word_index  (rsp_word_index),
   .rsp_last_word   (rsp_last_word)
);

FILE: bench/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import s256h_pkg::*;

   typedef enum logic {MODE_ABSORB = 1'b0, MODE_FINAL = 1'b1} mode_type;

   typedef struct packed {
      logic        mode;
      logic [7:0]  data;
      logic        has_golden;
      logic [31:0] golden_h0;
   } stim_row_type;

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_beat_type;

   localparam int LIMIT_CYCLES = 400000;
   localparam logic [31:0] EMPTY_H0 = 32'he3b0c442;
   localparam logic [31:0] ABC_H0   = 32'hba7816bf;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_mode;
   logic [7:0]  req_data_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   word_type    rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;

   sha256_stream_hasher_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_mode(req_mode), .req_data_byte(req_data_byte),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_digest_word(rsp_digest_word), .rsp_word_index(rsp_word_index),
      .rsp_last_word(rsp_last_word)
   );

   logic [31:0] hash_state [8];
   logic [7:0]  byte_buf [64];
   int unsigned buf_fill;
   logic [63:0] bit_len;
   digest_beat_type digest_q [$];
   logic [31:0] golden_q [$];
   int unsigned errors;
   int unsigned cycles;
   stim_row_type rows [$];

   localparam logic [31:0] SHA_IV [8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372,
      32'ha54ff53a, 32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
   localparam logic [31:0] SHA_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   function automatic logic [31:0] rotr(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic compress_block();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] t1, t2;
      for (int t = 0; t < 16; t++)
         w[t] = {byte_buf[4*t], byte_buf[4*t+1], byte_buf[4*t+2], byte_buf[4*t+3]};
      for (int t = 16; t < 64; t++)
         w[t] = w[t-16] + (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3))
              + w[t-7] + (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10));
      for (int i = 0; i < 8; i++) v[i] = hash_state[i];
      for (int t = 0; t < 64; t++) begin
         t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[t] + w[t];
         t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash_state[i] += v[i];
   endtask

   task automatic hash_reset();
      for (int i = 0; i < 8; i++) hash_state[i] = SHA_IV[i];
      buf_fill = 0;
      bit_len = '0;
   endtask

   task automatic hash_accept(logic mode, logic [7:0] data);
      digest_beat_type b;
      if (mode == MODE_ABSORB) begin
         byte_buf[buf_fill] = data;
         buf_fill++;
         bit_len += 64'd8;
         if (buf_fill == 64) begin
            compress_block();
            buf_fill = 0;
         end
      end else begin
         byte_buf[buf_fill] = PAD_BYTE;
         for (int i = buf_fill + 1; i < 64; i++) byte_buf[i] = 8'h00;
         if (buf_fill >= 56) begin
            compress_block();
            for (int i = 0; i < 64; i++) byte_buf[i] = 8'h00;
         end
         for (int i = 0; i < 8; i++) byte_buf[56+i] = bit_len[63-8*i -: 8];
         compress_block();
         for (int i = 0; i < 8; i++) begin
            b.word = hash_state[i];
            b.index = i[2:0];
            b.last = (i == 7);
            digest_q.push_back(b);
         end
         hash_reset();
      end
   endtask

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // scoreboard and input acceptance at rising edge
   always @(posedge clock) begin
      digest_beat_type e;
      if (!reset) begin
         cycles <= cycles + 1;
         if (req_valid && req_ready) hash_accept(req_mode, req_data_byte);
         if (rsp_valid && rsp_ready) begin
            if (digest_q.size() == 0) begin
               $error("unexpected digest beat %h", rsp_digest_word);
               errors++;
            end else begin
               e = digest_q.pop_front();
               if (rsp_word_index == 3'd0 && golden_q.size() != 0) begin
                  if (golden_q[0] !== rsp_digest_word) begin
                     $error("digest_word golden exp %h got %h", golden_q[0],
                        rsp_digest_word);
                     errors++;
                  end
                  void'(golden_q.pop_front());
               end
               if (e.word !== rsp_digest_word) begin
                  $error("digest_word exp %h got %h", e.word, rsp_digest_word);
                  errors++;
               end
               if (e.index !== rsp_word_index) begin
                  $error("word_index exp %0d got %0d", e.index, rsp_word_index);
                  errors++;
               end
               if (e.last !== rsp_last_word) begin
                  $error("last_word exp %0d got %0d", e.last, rsp_last_word);
                  errors++;
               end
            end
         end
         if (cycles > LIMIT_CYCLES) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // receiver stall pattern
   always @(negedge clock) begin
      int unsigned ph;
      ph = cycles % 40;
      if (reset) rsp_ready <= 1'b0;
      else if (ph < 12) rsp_ready <= 1'b1;
      else rsp_ready <= ($urandom_range(0, 2) != 0);
   end

   function automatic stim_row_type mk(logic mode, logic [7:0] data);
      stim_row_type r;
      r.mode = mode; r.data = data; r.has_golden = 1'b0; r.golden_h0 = '0;
      return r;
   endfunction

   task automatic send_row(stim_row_type r);
      @(negedge clock);
      req_valid <= 1'b1;
      req_mode <= r.mode;
      req_data_byte <= r.data;
      if (r.has_golden) golden_q.push_back(r.golden_h0);
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic add_message(int unsigned len, bit rand_data);
      for (int unsigned i = 0; i < len; i++)
         rows.push_back(mk(MODE_ABSORB, rand_data ? 8'($urandom) : 8'(i)));
      rows.push_back(mk(MODE_FINAL, 8'($urandom)));
   endtask

   initial begin
      stim_row_type r;
      int unsigned burst;
      hash_reset();
      errors = 0;
      cycles = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = 1'b0;
      req_data_byte = 8'h00;
      rsp_ready = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      r = mk(MODE_FINAL, 8'hff); r.has_golden = 1'b1; r.golden_h0 = EMPTY_H0;
      rows.push_back(r);
      rows.push_back(mk(MODE_ABSORB, 8'h61));
      rows.push_back(mk(MODE_ABSORB, 8'h62));
      rows.push_back(mk(MODE_ABSORB, 8'h63));
      r = mk(MODE_FINAL, 8'h00); r.has_golden = 1'b1; r.golden_h0 = ABC_H0;
      rows.push_back(r);
      rows.push_back(mk(MODE_ABSORB, 8'h00));
      rows.push_back(mk(MODE_ABSORB, 8'hff));
      rows.push_back(mk(MODE_FINAL, 8'h00));
      add_message(55, 1'b0);
      add_message(56, 1'b1);
      add_message(63, 1'b1);
      add_message(64, 1'b1);
      while (rows.size() < 270) begin
         case ($urandom_range(0, 2))
            0: add_message($urandom_range(0, 3), 1'b1);
            default: add_message($urandom_range(0, 12), 1'b1);
         endcase
      end

      while (rows.size() != 0) begin
         burst = $urandom_range(1, 20);
         while (burst != 0 && rows.size() != 0) begin
            send_row(rows.pop_front());
            burst--;
         end
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 6)) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b0;

      while (digest_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0 && digest_q.size() == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end
endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/s256h_pkg.sv
hw/rtl/sha256_stream_hasher.sv
hw/rtl/s256h_checker.sv
bench/testbench.sv
